@@ rtl/skhm_pkg.sv @@
// Package for the string key hash map: sizes, hash constants, status codes and helpers.
package skhm_pkg;

    localparam int unsigned SLOTS_DEF         = 128;
    localparam int unsigned MAX_KEY_BYTES_DEF = 39;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    // One FNV-1a step: xor in the byte, then multiply by the prime modulo 2^32.
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        begin
            x = h ^ {24'd0, b};
            return x * HASH_PRIME;
        end
    endfunction

endpackage

@@ rtl/skhm_ram.sv @@
// Generic single-port RAM with a registered read.
module skhm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH < 2) ? 1 : $clog2(DEPTH))-1:0] addr,
    input  logic [WIDTH-1:0]                              wdata,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/string_key_hash_map.sv @@
// Top level of the string key hash map: key intake, hash, probe sequencer and slot storage.
//
// Keys arrive one byte per item. Each byte is hashed (32-bit FNV-1a) and, up to
// MAX_KEY_BYTES, stored in a key buffer RAM in the cycle it is accepted, so s_ready
// stays high while a key streams in. The item that carries key_last starts a
// linear probe from hash modulo SLOTS, and s_ready is low from that item until its
// result has been loaded into the output register. When SLOTS is a power of two the
// start slot is taken from the low hash bits at once; otherwise the hash is first
// reduced by a shared compare-and-subtract in S_MOD. Each probed slot then has
// its used bit, length and value read in S_SLOT_RD and checked in S_SLOT_CHK; when
// the lengths agree, each key byte is compared through S_CMP_RD and S_CMP_CHK; the
// comparison walks the key buffer and the slot's key bytes one byte at a time
// through one shared byte comparator. A put that takes a free slot copies the key
// byte by byte through S_CPY_RD and S_CPY_WR. S_FINISH loads the result into the
// output register once that is free. A key longer than MAX_KEY_BYTES reports
// status 3 without touching the table, and so does a put on a full table with
// status 2. The output register holds a result until it is taken, and the next
// key may stream in meanwhile; only the result of a further key waits for it, in
// S_FINISH. After reset a clearing pass walks the used bits of all SLOTS slots to
// zero; no item is accepted during it.
module string_key_hash_map
    import skhm_pkg::*;
#(
    parameter int unsigned SLOTS         = SLOTS_DEF,
    parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_key_byte,
    input  logic        s_key_last,
    input  logic signed [63:0] s_put_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic signed [63:0] m_read_value
);

    localparam int unsigned SW  = $clog2(SLOTS);
    localparam int unsigned KW  = (MAX_KEY_BYTES < 2) ? 1 : $clog2(MAX_KEY_BYTES);
    localparam int unsigned LW  = $clog2(MAX_KEY_BYTES + 2);
    localparam int unsigned KBD = SLOTS * MAX_KEY_BYTES;
    localparam int unsigned KBW = $clog2(KBD);
    localparam int unsigned CW  = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] MAXLEN = LW'(MAX_KEY_BYTES);
    localparam bit          SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam logic [32:0] DVS_TOP    = 33'(SLOTS) << (32 - SW);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MOD, S_SLOT_RD, S_SLOT_CHK, S_CMP_RD, S_CMP_CHK,
        S_CPY_RD, S_CPY_WR, S_FINISH
    } state_t;

    state_t         state_reg, state_next;
    logic [31:0]    hash_reg, hash_next;
    logic [LW-1:0]  plen_reg, plen_next;
    logic           req_reg, req_next;
    logic [63:0]    val_reg, val_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [SW:0]    probes_reg, probes_next;
    logic [KW-1:0]  bidx_reg, bidx_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [1:0]     status_reg, status_next;
    logic [63:0]    rval_reg, rval_next;
    logic           mvalid_reg, mvalid_next;
    logic [1:0]     mstat_reg, mstat_next;
    logic [63:0]    mres_reg, mres_next;
    logic [32:0]    dvs_reg, dvs_next;

    // Used bits live in their own RAM and are cleared by the sweep after reset.
    logic           used_we;
    logic           used_wd;
    logic [SW-1:0]  used_addr;
    logic           used_rdata;

    logic [31:0]   hash_new;
    logic [31:0]   hash_red;
    logic          s_fire;
    logic [SW-1:0] slot_inc;

    // Key buffer RAM.
    logic          pk_we;
    logic [KW-1:0] pk_addr;
    logic [7:0]    pk_rdata;
    // Slot key bytes RAM.
    logic           kb_we;
    logic [KBW-1:0] kb_addr;
    logic [7:0]     kb_rdata;
    // Slot length and value RAMs share the slot address.
    logic           meta_we;
    logic [SW-1:0]  meta_addr;
    logic [LW-1:0]  len_rdata;
    logic           val_we;
    logic [63:0]    val_rdata;
    logic [SW-1:0]  clr_idx;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign hash_new = fnv_step(hash_reg, s_key_byte);
    assign m_valid  = mvalid_reg;
    assign m_status = mstat_reg;
    assign m_read_value = mres_reg;
    assign clr_idx  = probes_reg[SW-1:0];
    assign used_addr = (state_reg == S_CLEAR) ? clr_idx : slot_reg;
    // The probe steps to the next slot and wraps after the last one.
    assign slot_inc = (slot_reg == SW'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;

    skhm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
        .aclk(aclk), .we(used_we), .addr(used_addr), .wdata(used_wd), .rdata(used_rdata)
    );
    skhm_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_pend (
        .aclk(aclk), .we(pk_we), .addr(pk_addr), .wdata(s_key_byte), .rdata(pk_rdata)
    );
    skhm_ram #(.WIDTH(8), .DEPTH(KBD)) u_keys (
        .aclk(aclk), .we(kb_we), .addr(kb_addr), .wdata(pk_rdata), .rdata(kb_rdata)
    );
    skhm_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_len (
        .aclk(aclk), .we(meta_we), .addr(meta_addr), .wdata(plen_reg), .rdata(len_rdata)
    );
    skhm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val (
        .aclk(aclk), .we(val_we), .addr(meta_addr), .wdata(val_reg), .rdata(val_rdata)
    );

    // Byte address of the current slot's key byte; one multiply by a constant.
    assign kb_addr = KBW'(slot_reg * MAX_KEY_BYTES) + KBW'(bidx_reg);

    always_comb begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        plen_next   = plen_reg;
        req_next    = req_reg;
        val_next    = val_reg;
        slot_next   = slot_reg;
        probes_next = probes_reg;
        bidx_next   = bidx_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rval_next   = rval_reg;
        mvalid_next = mvalid_reg;
        mstat_next  = mstat_reg;
        mres_next   = mres_reg;
        dvs_next    = dvs_reg;
        hash_red    = hash_reg;
        used_we     = 1'b0;
        used_wd     = 1'b0;
        pk_we       = 1'b0;
        pk_addr     = bidx_reg;
        kb_we       = 1'b0;
        meta_we     = 1'b0;
        meta_addr   = slot_reg;
        val_we      = 1'b0;

        // A waiting result leaves the output register once it is taken.
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                used_we     = 1'b1;
                probes_next = probes_reg + 1'b1;
                if (probes_reg == (SW+1)'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                pk_addr = plen_reg[KW-1:0];
                if (s_fire) begin
                    hash_next = hash_new;
                    pk_we     = (plen_reg < MAXLEN);
                    if (plen_reg <= MAXLEN) begin
                        plen_next = plen_reg + 1'b1;
                    end
                    if (s_key_last) begin
                        req_next    = s_req_type;
                        val_next    = s_put_value;
                        slot_next   = hash_new[SW-1:0];
                        probes_next = '0;
                        bidx_next   = '0;
                        rval_next   = '0;
                        if (plen_reg >= MAXLEN) begin
                            status_next = ST_TOO_LONG;
                            state_next  = S_FINISH;
                        end else if (!s_req_type && count_reg == CW'(SLOTS)) begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end else if (SLOTS_POW2) begin
                            state_next = S_SLOT_RD;
                        end else begin
                            dvs_next   = DVS_TOP;
                            state_next = S_MOD;
                        end
                    end
                end
            end
            S_MOD: begin
                // Restoring reduction: subtract SLOTS shifted down one place per cycle.
                if ({1'b0, hash_reg} >= dvs_reg) begin
                    hash_red = hash_reg - dvs_reg[31:0];
                end
                hash_next = hash_red;
                dvs_next  = dvs_reg >> 1;
                if (dvs_reg == 33'(SLOTS)) begin
                    slot_next  = hash_red[SW-1:0];
                    state_next = S_SLOT_RD;
                end
            end
            S_SLOT_RD: begin
                state_next = S_SLOT_CHK;
            end
            S_SLOT_CHK: begin
                bidx_next = '0;
                if (!used_rdata) begin
                    if (req_reg) begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_FINISH;
                    end else begin
                        used_we     = 1'b1;
                        used_wd     = 1'b1;
                        meta_we     = 1'b1;
                        val_we      = 1'b1;
                        count_next  = count_reg + 1'b1;
                        status_next = ST_OK;
                        state_next  = S_CPY_RD;
                    end
                end else if (len_rdata == plen_reg) begin
                    state_next = S_CMP_RD;
                end else begin
                    probes_next = probes_reg + 1'b1;
                    slot_next   = slot_inc;
                    if (probes_reg == (SW+1)'(SLOTS - 1)) begin
                        status_next = req_reg ? ST_NOT_FOUND : ST_FULL;
                        state_next  = S_FINISH;
                    end else begin
                        state_next = S_SLOT_RD;
                    end
                end
            end
            S_CMP_RD: begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (pk_rdata != kb_rdata) begin
                    probes_next = probes_reg + 1'b1;
                    slot_next   = slot_inc;
                    if (probes_reg == (SW+1)'(SLOTS - 1)) begin
                        status_next = req_reg ? ST_NOT_FOUND : ST_FULL;
                        state_next  = S_FINISH;
                    end else begin
                        state_next = S_SLOT_RD;
                    end
                end else if (LW'(bidx_reg) + 1'b1 == plen_reg) begin
                    status_next = ST_OK;
                    if (req_reg) begin
                        rval_next = val_rdata;
                    end else begin
                        val_we = 1'b1;
                    end
                    state_next = S_FINISH;
                end else begin
                    bidx_next  = bidx_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_CPY_RD: begin
                state_next = S_CPY_WR;
            end
            S_CPY_WR: begin
                // The key buffer byte read last cycle is on pk_rdata now.
                kb_we = 1'b1;
                if (LW'(bidx_reg) + 1'b1 == plen_reg) begin
                    state_next = S_FINISH;
                end else begin
                    bidx_next  = bidx_reg + 1'b1;
                    state_next = S_CPY_RD;
                end
            end
            S_FINISH: begin
                if (!mvalid_reg || m_ready) begin
                    hash_next   = HASH_BASIS;
                    plen_next   = '0;
                    mvalid_next = 1'b1;
                    mstat_next  = status_reg;
                    mres_next   = rval_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            hash_reg   <= HASH_BASIS;
            plen_reg   <= '0;
            probes_reg <= '0;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            plen_reg   <= plen_next;
            probes_reg <= probes_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
        req_reg    <= req_next;
        val_reg    <= val_next;
        slot_reg   <= slot_next;
        bidx_reg   <= bidx_next;
        status_reg <= status_next;
        rval_reg   <= rval_next;
        mstat_reg  <= mstat_next;
        mres_reg   <= mres_next;
        dvs_reg    <= dvs_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !m_valid)
        else $error("result offered during the clearing pass");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(SLOTS))
        else $error("entry count above slot count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_status) && $stable(m_read_value)))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && (!m_valid || m_ready)) |=> m_valid)
        else $error("finish did not raise a result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_read_value == '0))
        else $error("value returned with a failing status");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the string key hash map: directed keys, random keys, table fill.
module testbench;
    import skhm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = SLOTS_DEF;
    localparam int MAXK   = MAX_KEY_BYTES_DEF;

    // One input item as it goes onto the s_ channel. The last byte of a key may
    // carry a typed-in expectation; otherwise the shadow table decides.
    typedef struct {
        logic               req;
        logic [7:0]         kbyte;
        logic               last;
        logic signed [63:0] val;
        bit                 typed;
        status_t            t_st;
        logic signed [63:0] t_val;
        int                 ph;
    } item_t;

    typedef struct {
        status_t            st;
        logic signed [63:0] v;
    } reply_t;

    // One directed key: the same byte repeated len times.
    typedef struct {
        logic               req;
        logic [7:0]         kbyte;
        int                 len;
        logic signed [63:0] val;
        bit                 typed;
        status_t            t_st;
        logic signed [63:0] t_val;
    } key_row_t;

    localparam logic PUT = 1'b0;
    localparam logic GET = 1'b1;
    localparam logic signed [63:0] VMAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [7:0]  s_key_byte = 8'd1;
    logic        s_key_last = 1'b0;
    logic signed [63:0] s_put_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic signed [63:0] m_read_value;

    string_key_hash_map dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_key_byte   (s_key_byte),
        .s_key_last   (s_key_last),
        .s_put_value  (s_put_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_value (m_read_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the table and of the key that is being received.
    logic               tbl_used [NSLOTS];
    logic [7:0]         tbl_key  [NSLOTS][MAXK];
    int                 tbl_len  [NSLOTS];
    logic signed [63:0] tbl_val  [NSLOTS];
    int                 tbl_count = 0;
    logic [7:0]         rx_key [MAXK];
    int                 rx_len = 0;
    logic [31:0]        rx_hash = HASH_BASIS;

    item_t  stim [$];
    reply_t replies [$];
    int     pos = 0;
    int     errors = 0;
    bit     running = 1'b0;
    int     phase_r = 0;
    int     ph0_start = 0;
    int     hold_cnt = 0;
    bit     held = 1'b0;

    initial begin
        for (int s = 0; s < NSLOTS; s++) begin
            tbl_used[s] = 1'b0;
        end
    end

    function automatic bit slot_holds_rx_key(int s);
        if (tbl_len[s] != rx_len) begin
            return 1'b0;
        end
        for (int i = 0; i < rx_len; i++) begin
            if (tbl_key[s][i] != rx_key[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Takes one accepted key byte into the shadow table. On the last byte of a
    // key it carries out the put or get and returns the reply it should cause.
    task automatic hash_map_absorb(input item_t it, output bit has_reply, output reply_t r);
        int slot;
        int home;
        rx_hash = (rx_hash ^ {24'd0, it.kbyte}) * HASH_PRIME;
        if (rx_len < MAXK) begin
            rx_key[rx_len] = it.kbyte;
        end
        if (rx_len <= MAXK) begin
            rx_len++;
        end
        has_reply = it.last;
        r.st = ST_NOT_FOUND;
        r.v = '0;
        if (!it.last) begin
            return;
        end
        home = int'(rx_hash % NSLOTS);
        if (rx_len > MAXK) begin
            r.st = ST_TOO_LONG;
        end else if (it.req == PUT) begin
            // A full table refuses every put, updates included.
            r.st = ST_FULL;
            if (tbl_count < NSLOTS) begin
                for (int i = 0; i < NSLOTS; i++) begin
                    slot = (home + i) % NSLOTS;
                    if (!tbl_used[slot]) begin
                        for (int k = 0; k < rx_len; k++) begin
                            tbl_key[slot][k] = rx_key[k];
                        end
                        tbl_len[slot] = rx_len;
                        tbl_used[slot] = 1'b1;
                        tbl_val[slot] = it.val;
                        tbl_count++;
                        r.st = ST_OK;
                        break;
                    end
                    if (slot_holds_rx_key(slot)) begin
                        tbl_val[slot] = it.val;
                        r.st = ST_OK;
                        break;
                    end
                end
            end
        end else begin
            for (int i = 0; i < NSLOTS; i++) begin
                slot = (home + i) % NSLOTS;
                if (!tbl_used[slot]) begin
                    break;
                end
                if (slot_holds_rx_key(slot)) begin
                    r.st = ST_OK;
                    r.v = tbl_val[slot];
                    break;
                end
            end
        end
        rx_len = 0;
        rx_hash = HASH_BASIS;
    endtask

    // Sender idles 13% in phase 0 and 50% in phase 1; receiver the other way round.
    function automatic int idle_pct(int ph, bit rx_side);
        if (ph == 0) begin
            return rx_side ? 50 : 13;
        end
        if (ph == 1) begin
            return rx_side ? 13 : 50;
        end
        return 0;
    endfunction

    // Driver and checker in one clocked process: all channel signals are sampled
    // at the edge, before the block's own updates land, so order does not matter.
    always @(posedge aclk) begin
        bit     got;
        reply_t r;
        reply_t want;
        if (aresetn && s_valid && s_ready) begin
            hash_map_absorb(stim[pos], got, r);
            if (got) begin
                if (stim[pos].typed) begin
                    r.st = stim[pos].t_st;
                    r.v = stim[pos].t_val;
                end
                replies.push_back(r);
            end
            phase_r <= stim[pos].ph;
            pos++;
        end
        if (aresetn && (!s_valid || s_ready)) begin
            if (running && pos < stim.size()
                    && $urandom_range(99) >= idle_pct(stim[pos].ph, 1'b0)) begin
                s_valid     <= 1'b1;
                s_req_type  <= stim[pos].req;
                s_key_byte  <= stim[pos].kbyte;
                s_key_last  <= stim[pos].last;
                s_put_value <= stim[pos].val;
            end else begin
                s_valid <= 1'b0;
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (replies.size() == 0) begin
                $error("result item with no expectation waiting: status %0d value %0d",
                       m_status, m_read_value);
                errors++;
            end else begin
                want = replies.pop_front();
                if (m_status !== want.st) begin
                    $error("status: expected %0d, actual %0d", want.st, m_status);
                    errors++;
                end
                if (m_read_value !== want.v) begin
                    $error("read_value: expected %0d, actual %0d", want.v, m_read_value);
                    errors++;
                end
            end
        end
    end

    // Early in the first random phase the receiver holds off for 400 cycles,
    // counted here, while the sender keeps offering items, so the block has to
    // stall its input.
    always @(posedge aclk) begin
        if (!held && running && pos >= ph0_start + 20) begin
            held     <= 1'b1;
            hold_cnt <= 400;
            m_ready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct(phase_r, 1'b1));
        end
    end

    task automatic add_key(input logic req, input logic [7:0] kb[$], input logic signed [63:0] v,
                           input bit typed, input status_t st, input logic signed [63:0] ev,
                           input int ph);
        item_t it;
        for (int i = 0; i < kb.size(); i++) begin
            it.req   = req;
            it.kbyte = kb[i];
            it.last  = (i == kb.size() - 1);
            it.val   = v;
            it.typed = typed;
            it.t_st  = st;
            it.t_val = ev;
            it.ph    = ph;
            stim.push_back(it);
        end
    endtask

    function automatic logic signed [63:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // Directed keys: the widest values, the longest legal key, keys one and two bytes
    // too long, a zero byte, an update, and lookups that hit and miss.
    key_row_t directed [] = '{
        '{GET, 8'h41,  1, 64'sd0,  1'b1, ST_NOT_FOUND, 64'sd0},
        '{PUT, 8'h41,  1, VMAX,    1'b1, ST_OK,        64'sd0},
        '{GET, 8'h41,  1, 64'sd0,  1'b1, ST_OK,        VMAX},
        '{PUT, 8'hFF, 39, VMIN,    1'b1, ST_OK,        64'sd0},
        '{GET, 8'hFF, 39, 64'sd0,  1'b1, ST_OK,        VMIN},
        '{PUT, 8'h01, 40, 64'sd7,  1'b1, ST_TOO_LONG,  64'sd0},
        '{GET, 8'h80, 41, 64'sd0,  1'b1, ST_TOO_LONG,  64'sd0},
        '{PUT, 8'h00,  1, -64'sd1, 1'b1, ST_OK,        64'sd0},
        '{GET, 8'h00,  1, 64'sd0,  1'b1, ST_OK,        -64'sd1},
        '{PUT, 8'h41,  1, 64'sd5,  1'b1, ST_OK,        64'sd0},
        '{GET, 8'h41,  1, 64'sd0,  1'b1, ST_OK,        64'sd5},
        '{GET, 8'hFF, 38, 64'sd0,  1'b0, ST_OK,        64'sd0},
        '{PUT, 8'h55,  2, 64'sd9,  1'b0, ST_OK,        64'sd0},
        '{GET, 8'hAA,  2, 64'sd0,  1'b0, ST_OK,        64'sd0}
    };

    logic [7:0] pool [16][$];

    initial begin
        logic [7:0] kb[$];
        int         pick;
        int         n;
        // Directed part.
        foreach (directed[d]) begin
            kb = {};
            for (int i = 0; i < directed[d].len; i++) begin
                kb.push_back(directed[d].kbyte);
            end
            add_key(directed[d].req, kb, directed[d].val, directed[d].typed,
                    directed[d].t_st, directed[d].t_val, 2);
        end
        // A small pool of keys so that puts and gets meet often; one is the
        // longest legal key.
        for (int p = 0; p < 16; p++) begin
            n = (p == 15) ? MAXK : $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                pool[p].push_back(8'($urandom_range(1, 255)));
            end
        end
        // Random part, three idling phases of about 100 items each.
        ph0_start = stim.size();
        for (int ph = 0; ph < 3; ph++) begin
            n = stim.size() + 100;
            while (stim.size() < n) begin
                pick = $urandom_range(99);
                kb = {};
                if (pick < 3) begin
                    for (int i = $urandom_range(MAXK + 1, MAXK + 6); i > 0; i--) begin
                        kb.push_back(8'($urandom_range(1, 255)));
                    end
                end else if (pick < 13) begin
                    for (int i = $urandom_range(1, 8); i > 0; i--) begin
                        kb.push_back(8'($urandom_range(1, 255)));
                    end
                end else begin
                    kb = pool[$urandom_range(15)];
                end
                add_key($urandom_range(1) ? GET : PUT, kb, rand_value(), 1'b0, ST_OK,
                        64'sd0, ph);
            end
        end
        // Fill the table past capacity, then try an update and two lookups on a
        // full table; the miss uses zero bytes that no random key carries and has
        // to walk every slot.
        for (int i = 0; i < NSLOTS + 12; i++) begin
            add_key(PUT, {8'hC3, 8'(i + 1)}, rand_value(), 1'b0, ST_OK, 64'sd0, 2);
        end
        add_key(PUT, pool[0], rand_value(), 1'b1, ST_FULL, 64'sd0, 2);
        add_key(GET, {8'h00, 8'h00}, 64'sd0, 1'b1, ST_NOT_FOUND, 64'sd0, 2);
        add_key(GET, {8'hC3, 8'd3}, 64'sd0, 1'b0, ST_OK, 64'sd0, 2);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        running = 1'b1;
        wait (pos == stim.size() && replies.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && replies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Generous bound: well above the slowest legal run, including full-table walks.
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
